FILE: rtl/deadline_timer_queue_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the deadline timer queue
// Shorthand for clocked checks that are disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_ASSERT_SVH

// Check that an expression holds at every clock edge out of reset
`define DTQ_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// Check that a condition implies a consequence in the same cycle
`define DTQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

// Check that a condition implies a consequence in the next cycle
`define DTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

FILE: rtl/dtq_pkg.sv
// ---------------------------------------------------------------------------
// Deadline timer queue package
// Field widths, operation and status codes, and the slot and control types.
// ---------------------------------------------------------------------------
package dtq_pkg;

    localparam int DL_W     = 64;
    localparam int ID_W     = 64;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 5;
    localparam int MAX_OUT  = 16;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COLLECT = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NONE      = 2'd3;

    // Cell operations
    typedef logic [1:0] t_op;
    localparam t_op OP_HOLD   = 2'd0;
    localparam t_op OP_INSERT = 2'd1;
    localparam t_op OP_POP    = 2'd2;
    localparam t_op OP_CANCEL = 2'd3;

    // One timer slot
    typedef struct packed {
        logic            valid;
        logic [DL_W-1:0] deadline;
        logic [ID_W-1:0] id;
    } t_slot;

    // Command broadcast to every cell
    typedef struct packed {
        t_op             op;
        logic [DL_W-1:0] key;
        logic [ID_W-1:0] new_id;
    } t_ctl;

endpackage

FILE: rtl/dtq_cell.sv
// ---------------------------------------------------------------------------
// Deadline timer queue cell
// Holds one timer slot and moves it toward either neighbor on insert, pop
// and cancel, keeping the chain sorted by deadline.
// ---------------------------------------------------------------------------
module dtq_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dtq_pkg::t_ctl              i_ctl,
    input  dtq_pkg::t_slot             i_left,
    input  logic                       i_left_le,
    input  dtq_pkg::t_slot             i_right,
    input  logic                       i_found_in,
    output dtq_pkg::t_slot             o_slot,
    output logic                       o_le,
    output logic                       o_found_out,
    output logic [dtq_pkg::DL_W-1:0]   o_sel_deadline
);
    import dtq_pkg::*;

    logic            r_valid;
    logic [DL_W-1:0] r_deadline;
    logic [ID_W-1:0] r_id;
    logic            r_hit;
    t_slot           n_slot;
    logic            w_hit;

    // Compare the stored slot against the broadcast key
    assign o_le        = r_valid && (r_deadline <= i_ctl.key);
    assign w_hit       = r_valid && (r_id == i_ctl.key);
    assign o_found_out = i_found_in | r_hit;
    assign o_sel_deadline = (r_hit && !i_found_in) ? r_deadline : '0;
    assign o_slot      = '{valid: r_valid, deadline: r_deadline, id: r_id};

    // Pick the next slot contents
    always_comb begin
        n_slot = o_slot;
        case (i_ctl.op)
            OP_INSERT: begin
                if (!o_le) begin
                    if (i_left_le) begin
                        n_slot = '{valid: 1'b1, deadline: i_ctl.key, id: i_ctl.new_id};
                    end else begin
                        n_slot = i_left;
                    end
                end
            end
            OP_POP: begin
                n_slot = i_right;
            end
            OP_CANCEL: begin
                if (o_found_out) begin
                    n_slot = i_right;
                end
            end
            default: begin
                n_slot = o_slot;
            end
        endcase
    end

    // Hold valid and the registered id match under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= n_slot.valid;
            r_hit   <= w_hit;
        end
    end

    // Advance the slot payload
    always_ff @(posedge i_clk) begin
        r_deadline <= n_slot.deadline;
        r_id       <= n_slot.id;
    end

endmodule

FILE: rtl/deadline_timer_queue.sv
// Insert passes through S_INSERT, cancel through S_CAN_CMP then S_CAN_DEL, and collect stays
// in S_COLLECT (one expired timer leaves the head cell per cycle); each result is registered.
// Throughput: a new item is taken in the cycle the last result is on the ports.
// The id match of a cancel is registered in each cell before the removal cycle.
// Synchronous active-low reset empties every cell and zeroes the id counter.
// Results cannot be stalled: each is shown for one cycle under o_result_valid.
`include "deadline_timer_queue_assert.svh"
// ---------------------------------------------------------------------------
// Deadline timer queue
// Sorted chain of timer cells with insert, cancel by id and collect of
// expired timers in deadline order.
// ---------------------------------------------------------------------------
module deadline_timer_queue #(
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [dtq_pkg::KIND_W-1:0]       i_kind,
    input  logic [dtq_pkg::DL_W-1:0]         i_deadline,
    input  logic [dtq_pkg::ID_W-1:0]         i_cancel_id,
    input  logic [dtq_pkg::DL_W-1:0]         i_now_time,
    input  logic [dtq_pkg::LIMIT_W-1:0]      i_limit,
    output logic                             o_result_valid,
    output logic [dtq_pkg::STATUS_W-1:0]     o_status,
    output logic [dtq_pkg::ID_W-1:0]         o_result_id,
    output logic [dtq_pkg::DL_W-1:0]         o_result_deadline,
    output logic                             o_last
);
    import dtq_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INSERT  = 3'd1;
    localparam logic [2:0] S_CAN_CMP = 3'd2;
    localparam logic [2:0] S_CAN_DEL = 3'd3;
    localparam logic [2:0] S_COLLECT = 3'd4;

    logic [2:0]          r_state,  n_state;
    logic [DL_W-1:0]     r_key,    n_key;
    logic [LIMIT_W-1:0]  r_lim,    n_lim;
    logic [LIMIT_W-1:0]  r_cnt,    n_cnt;
    logic [ID_W-1:0]     r_id_counter, n_id_counter;
    logic                r_out_valid,  n_out_valid;
    logic [STATUS_W-1:0] r_status,     n_status;
    logic [ID_W-1:0]     r_res_id,     n_res_id;
    logic [DL_W-1:0]     r_res_dl,     n_res_dl;
    logic                r_last,       n_last;

    t_ctl            w_ctl;
    t_slot           w_slot  [DEPTH];
    logic            w_le    [DEPTH];
    logic            w_found [DEPTH];
    logic [DL_W-1:0] w_sel   [DEPTH];
    logic [DL_W-1:0] w_sel_deadline;
    logic [DEPTH-1:0] w_valid_vec;
    logic            w_accept;
    logic            w_full;
    logic            w_found_any;
    logic            w_pop_ok;
    logic            w_more;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Build the cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_left_le;
        logic  w_found_in;

        if (g == 0) begin : g_head
            assign w_left     = '0;
            assign w_left_le  = 1'b1;
            assign w_found_in = 1'b0;
        end else begin : g_body
            assign w_left     = w_slot[g-1];
            assign w_left_le  = w_le[g-1];
            assign w_found_in = w_found[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_slot[g+1];
        end

        dtq_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_left         (w_left),
            .i_left_le      (w_left_le),
            .i_right        (w_right),
            .i_found_in     (w_found_in),
            .o_slot         (w_slot[g]),
            .o_le           (w_le[g]),
            .o_found_out    (w_found[g]),
            .o_sel_deadline (w_sel[g])
        );

        assign w_valid_vec[g] = w_slot[g].valid;
    end

    // Gather the deadline of the first matching cell
    always_comb begin
        w_sel_deadline = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel_deadline = w_sel_deadline | w_sel[i];
        end
    end

    assign w_full      = w_slot[DEPTH-1].valid;
    assign w_found_any = w_found[DEPTH-1];
    assign w_pop_ok    = w_le[0] && (r_cnt < r_lim);
    assign w_more      = w_le[1] && ((r_cnt + LIMIT_W'(1)) < r_lim);

    // Drive the cell command
    always_comb begin
        w_ctl.op     = OP_HOLD;
        w_ctl.key    = r_key;
        w_ctl.new_id = r_id_counter + ID_W'(1);
        case (r_state)
            S_INSERT:  w_ctl.op = w_full ? OP_HOLD : OP_INSERT;
            S_CAN_DEL: w_ctl.op = OP_CANCEL;
            S_COLLECT: w_ctl.op = w_pop_ok ? OP_POP : OP_HOLD;
            default:   w_ctl.op = OP_HOLD;
        endcase
    end

    // Sequence each item and form its results
    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_lim        = r_lim;
        n_cnt        = r_cnt;
        n_id_counter = r_id_counter;
        n_out_valid  = 1'b0;
        n_status     = r_status;
        n_res_id     = r_res_id;
        n_res_dl     = r_res_dl;
        n_last       = r_last;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cnt = '0;
                    n_lim = (i_limit > LIMIT_W'(MAX_OUT)) ? LIMIT_W'(MAX_OUT) : i_limit;
                    case (i_kind)
                        KIND_INSERT: begin
                            n_key   = i_deadline;
                            n_state = S_INSERT;
                        end
                        KIND_CANCEL: begin
                            n_key   = i_cancel_id;
                            n_state = S_CAN_CMP;
                        end
                        KIND_COLLECT: begin
                            n_key   = i_now_time;
                            n_state = S_COLLECT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INSERT: begin
                n_out_valid = 1'b1;
                n_last      = 1'b1;
                n_res_dl    = r_key;
                if (w_full) begin
                    n_status = STAT_FULL;
                    n_res_id = '0;
                end else begin
                    n_status     = STAT_OK;
                    n_res_id     = w_ctl.new_id;
                    n_id_counter = w_ctl.new_id;
                end
                n_state = S_IDLE;
            end
            S_CAN_CMP: begin
                n_state = S_CAN_DEL;
            end
            S_CAN_DEL: begin
                n_out_valid = 1'b1;
                n_last      = 1'b1;
                n_res_id    = r_key;
                n_status    = w_found_any ? STAT_OK : STAT_NOT_FOUND;
                n_res_dl    = w_found_any ? w_sel_deadline : '0;
                n_state     = S_IDLE;
            end
            S_COLLECT: begin
                n_out_valid = 1'b1;
                if (w_pop_ok) begin
                    n_status = STAT_OK;
                    n_res_id = w_slot[0].id;
                    n_res_dl = w_slot[0].deadline;
                    n_last   = !w_more;
                    n_cnt    = r_cnt + LIMIT_W'(1);
                    if (!w_more) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_status = STAT_NONE;
                    n_res_id = '0;
                    n_res_dl = '0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_id_counter <= '0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_id_counter <= n_id_counter;
            r_out_valid  <= n_out_valid;
            r_cnt        <= n_cnt;
        end
    end

    // Advance the item payload and result registers
    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_lim    <= n_lim;
        r_status <= n_status;
        r_res_id <= n_res_id;
        r_res_dl <= n_res_dl;
        r_last   <= n_last;
    end

    assign o_result_valid    = r_out_valid;
    assign o_status          = r_status;
    assign o_result_id       = r_res_id;
    assign o_result_deadline = r_res_dl;
    assign o_last            = r_last;

    // Valid cells form a prefix of the chain
    `DTQ_ASSERT_ALWAYS(a_valid_prefix, i_clk, i_rst_n, ((w_valid_vec >> 1) & ~w_valid_vec) == '0)
    // The head two cells are in deadline order
    `DTQ_ASSERT_IMP(a_head_sorted, i_clk, i_rst_n, w_slot[1].valid, w_slot[0].deadline <= w_slot[1].deadline)
    // An accepted item never sees a result in the following cycle
    `DTQ_ASSERT_NEXT(a_accept_gap, i_clk, i_rst_n, w_accept, !o_result_valid)
    // A non-final collect result is followed at once by the next one
    `DTQ_ASSERT_NEXT(a_collect_burst, i_clk, i_rst_n, o_result_valid && !o_last, o_result_valid)
    // A full insert leaves the id counter alone
    `DTQ_ASSERT_IMP(a_full_no_id, i_clk, i_rst_n, o_result_valid && (o_status == STAT_FULL), $stable(r_id_counter))

endmodule
